FILE: rtl/esw_pkg.sv
package esw_pkg;

  // Field widths fixed by the port list
  localparam int unsigned ROTOR_LANES = 16;
  localparam int unsigned ENC_SW_W    = 16;
  localparam int unsigned SIDE_SW_W   = 8;

  // Default configuration of the panel
  localparam int unsigned NUM_ROTORS_DEF    = 16;
  localparam int unsigned WINDOW_DEPTH_DEF  = 10;
  localparam int unsigned ENC_SWITCHES_DEF  = 16;
  localparam int unsigned SIDE_SWITCHES_DEF = 8;

  // Switch combinations on the debounced / pressed encoder switch masks
  localparam logic [ENC_SW_W-1:0] BOOT_MASK_A = 16'h9009;
  localparam logic [ENC_SW_W-1:0] BOOT_MASK_B = 16'hCC00;
  localparam logic [ENC_SW_W-1:0] RESET_MASK  = 16'h8001;

  // Half-step quadrature states
  typedef enum logic [2:0] {
    R_START   = 3'd0,
    R_CCW_ARM = 3'd1,
    R_CW_ARM  = 3'd2,
    R_MID     = 3'd3,
    R_MID_CW  = 3'd4,
    R_MID_CCW = 3'd5
  } rotor_idx_t;

  typedef struct packed {
    rotor_idx_t idx;
    logic       cw;
    logic       ccw;
  } rotor_step_t;

  // Next state for one encoder; ab is {B, A}. Unknown codes act as start.
  function automatic rotor_step_t rotor_next(input rotor_idx_t cur, input logic [1:0] ab);
    rotor_step_t r;
    r.cw  = 1'b0;
    r.ccw = 1'b0;
    r.idx = R_START;
    unique case (cur)
      R_CCW_ARM: begin
        unique case (ab)
          2'd0: begin r.idx = R_MID; r.ccw = 1'b1; end
          2'd1: r.idx = R_START;
          2'd2: r.idx = R_CCW_ARM;
          default: r.idx = R_START;
        endcase
      end
      R_CW_ARM: begin
        unique case (ab)
          2'd0: begin r.idx = R_MID; r.cw = 1'b1; end
          2'd1: r.idx = R_CW_ARM;
          2'd2: r.idx = R_START;
          default: r.idx = R_START;
        endcase
      end
      R_MID: begin
        unique case (ab)
          2'd0: r.idx = R_MID;
          2'd1: r.idx = R_MID_CCW;
          2'd2: r.idx = R_MID_CW;
          default: r.idx = R_START;
        endcase
      end
      R_MID_CW: begin
        unique case (ab)
          2'd0: r.idx = R_MID;
          2'd1: r.idx = R_MID;
          2'd2: r.idx = R_MID_CW;
          default: begin r.idx = R_START; r.cw = 1'b1; end
        endcase
      end
      R_MID_CCW: begin
        unique case (ab)
          2'd0: r.idx = R_MID;
          2'd1: r.idx = R_MID_CCW;
          2'd2: r.idx = R_MID;
          default: begin r.idx = R_START; r.ccw = 1'b1; end
        endcase
      end
      default: begin
        // start state, and any code that should never be stored
        unique case (ab)
          2'd0: r.idx = R_MID;
          2'd1: r.idx = R_CW_ARM;
          2'd2: r.idx = R_CCW_ARM;
          default: r.idx = R_START;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/encoder_switch_scanner_unit.sv
// Scanner for a panel of quadrature encoders with push switches and side switches.
// Each input beat is one scan tick; each tick yields exactly one result beat with
// the step flags of every encoder, the debounced switch masks, their press and
// release edges, and the bootloader and reset combination flags. The block takes
// one beat per cycle when the output side is not stalled; a tick is held in the input
// register and its result is presented from the result register. A switch reads as on
// only after WINDOW_DEPTH consecutive ticks with it on, and goes off on the first
// tick that samples it off. Encoder switch pins are active low; side switch pins
// are active high.
module encoder_switch_scanner_unit #(
  parameter int unsigned NUM_ROTORS    = esw_pkg::NUM_ROTORS_DEF,
  parameter int unsigned WINDOW_DEPTH  = esw_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned ENC_SWITCHES  = esw_pkg::ENC_SWITCHES_DEF,
  parameter int unsigned SIDE_SWITCHES = esw_pkg::SIDE_SWITCHES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [esw_pkg::ROTOR_LANES-1:0] quad_a,
  input  logic [esw_pkg::ROTOR_LANES-1:0] quad_b,
  input  logic [esw_pkg::ENC_SW_W-1:0]    enc_switch_level,
  input  logic [esw_pkg::SIDE_SW_W-1:0]   side_switch_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [esw_pkg::ROTOR_LANES-1:0] cw_steps,
  output logic [esw_pkg::ROTOR_LANES-1:0] ccw_steps,
  output logic [esw_pkg::ENC_SW_W-1:0]    enc_switch_state,
  output logic [esw_pkg::ENC_SW_W-1:0]    enc_pressed,
  output logic [esw_pkg::ENC_SW_W-1:0]    enc_released,
  output logic [esw_pkg::SIDE_SW_W-1:0]   side_state,
  output logic [esw_pkg::SIDE_SW_W-1:0]   side_pressed,
  output logic [esw_pkg::SIDE_SW_W-1:0]   side_released,
  output logic                           bootloader_combo,
  output logic                           reset_combo
);

  logic                            s1_valid;
  logic [esw_pkg::ROTOR_LANES-1:0] s1_quad_a;
  logic [esw_pkg::ROTOR_LANES-1:0] s1_quad_b;
  logic [esw_pkg::ENC_SW_W-1:0]    s1_enc_level;
  logic [esw_pkg::SIDE_SW_W-1:0]   s1_side_level;
  logic                            advance;
  logic                            in_take;

  logic [esw_pkg::ROTOR_LANES-1:0] cw_next;
  logic [esw_pkg::ROTOR_LANES-1:0] ccw_next;
  logic [esw_pkg::ENC_SW_W-1:0]    enc_deb;
  logic [esw_pkg::ENC_SW_W-1:0]    enc_pr;
  logic [esw_pkg::ENC_SW_W-1:0]    enc_rl;
  logic [esw_pkg::SIDE_SW_W-1:0]   side_deb;
  logic [esw_pkg::SIDE_SW_W-1:0]   side_pr;
  logic [esw_pkg::SIDE_SW_W-1:0]   side_rl;
  logic                            boot_next;
  logic                            rst_combo_next;

  // Handshake: the input register moves on whenever the result register is free
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_quad_a     <= quad_a;
      s1_quad_b     <= quad_b;
      s1_enc_level  <= enc_switch_level;
      s1_side_level <= side_switch_level;
    end
  end

  // Encoder tables
  esw_rotor #(
    .NUM_ROTORS(NUM_ROTORS)
  ) u_rotor (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .quad_a   (s1_quad_a),
    .quad_b   (s1_quad_b),
    .cw_next  (cw_next),
    .ccw_next (ccw_next)
  );

  // Encoder push switches, active low at the pins
  esw_debounce #(
    .WIDTH  (esw_pkg::ENC_SW_W),
    .ACTIVE (ENC_SWITCHES),
    .DEPTH  (WINDOW_DEPTH)
  ) u_enc_deb (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .sample   (~s1_enc_level),
    .deb      (enc_deb),
    .pressed  (enc_pr),
    .released (enc_rl)
  );

  // Side switches, active high at the pins
  esw_debounce #(
    .WIDTH  (esw_pkg::SIDE_SW_W),
    .ACTIVE (SIDE_SWITCHES),
    .DEPTH  (WINDOW_DEPTH)
  ) u_side_deb (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .sample   (s1_side_level),
    .deb      (side_deb),
    .pressed  (side_pr),
    .released (side_rl)
  );

  // Switch combinations
  assign boot_next = ((enc_deb & esw_pkg::BOOT_MASK_A) == esw_pkg::BOOT_MASK_A) ||
                     ((enc_deb & esw_pkg::BOOT_MASK_B) == esw_pkg::BOOT_MASK_B);
  assign rst_combo_next = ((enc_pr & esw_pkg::RESET_MASK) == esw_pkg::RESET_MASK);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cw_steps         <= cw_next;
      ccw_steps        <= ccw_next;
      enc_switch_state <= enc_deb;
      enc_pressed      <= enc_pr;
      enc_released     <= enc_rl;
      side_state       <= side_deb;
      side_pressed     <= side_pr;
      side_released    <= side_rl;
      bootloader_combo <= boot_next;
      reset_combo      <= rst_combo_next;
    end
  end

  // Checks
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled while a stage was free");

  a_dir_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((cw_steps & ccw_steps) == '0))
    else $error("encoder flagged both directions");

  a_edge_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((enc_pressed & enc_released) == '0 &&
                   (side_pressed & side_released) == '0))
    else $error("switch pressed and released on one tick");

  a_pressed_is_on: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((enc_pressed & ~enc_switch_state) == '0 &&
                   (side_pressed & ~side_state) == '0))
    else $error("pressed switch not in debounced state");

  a_reset_combo_on: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reset_combo) |-> (enc_switch_state[0] && enc_switch_state[15]))
    else $error("reset combination without both switches on");

endmodule

FILE: rtl/esw_rotor.sv
module esw_rotor #(
  parameter int unsigned NUM_ROTORS = esw_pkg::NUM_ROTORS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic [esw_pkg::ROTOR_LANES-1:0] quad_a,
  input  logic [esw_pkg::ROTOR_LANES-1:0] quad_b,
  output logic [esw_pkg::ROTOR_LANES-1:0] cw_next,
  output logic [esw_pkg::ROTOR_LANES-1:0] ccw_next
);

  // One table lane per encoder; lanes past NUM_ROTORS stay quiet
  for (genvar n = 0; n < esw_pkg::ROTOR_LANES; n++) begin : g_lane
    if (n < NUM_ROTORS) begin : g_used
      esw_pkg::rotor_idx_t  rotor_state;
      esw_pkg::rotor_step_t step;

      assign step        = esw_pkg::rotor_next(rotor_state, {quad_b[n], quad_a[n]});
      assign cw_next[n]  = step.cw;
      assign ccw_next[n] = step.ccw;

      always_ff @(posedge clk) begin
        if (rst) begin
          rotor_state <= esw_pkg::R_START;
        end else if (advance) begin
          rotor_state <= step.idx;
        end
      end
    end else begin : g_unused
      assign cw_next[n]  = 1'b0;
      assign ccw_next[n] = 1'b0;
    end
  end

endmodule

FILE: rtl/esw_debounce.sv
module esw_debounce #(
  parameter int unsigned WIDTH  = esw_pkg::ENC_SW_W,
  parameter int unsigned ACTIVE = esw_pkg::ENC_SWITCHES_DEF,
  parameter int unsigned DEPTH  = esw_pkg::WINDOW_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [WIDTH-1:0] sample,
  output logic [WIDTH-1:0] deb,
  output logic [WIDTH-1:0] pressed,
  output logic [WIDTH-1:0] released
);

  localparam int unsigned PosW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] hist [DEPTH];
  logic [PosW-1:0]  pos;
  logic [PosW-1:0]  pos_next;
  logic [WIDTH-1:0] prev;
  logic [WIDTH-1:0] act_mask;
  logic [WIDTH-1:0] captured;
  logic [WIDTH-1:0] changed;

  // Switch bits past ACTIVE are captured as off
  for (genvar b = 0; b < WIDTH; b++) begin : g_mask
    assign act_mask[b] = (b < ACTIVE) ? 1'b1 : 1'b0;
  end

  assign captured = sample & act_mask;
  assign pos_next = (pos == PosW'(DEPTH - 1)) ? '0 : pos + 1'b1;

  // On only if every ring entry, with this beat's sample in place, is on
  always_comb begin
    deb = '1;
    for (int i = 0; i < DEPTH; i++) begin
      deb = deb & ((pos == PosW'(i)) ? captured : hist[i]);
    end
  end

  assign changed  = deb ^ prev;
  assign pressed  = changed & deb;
  assign released = changed & ~deb;

  // Ring, write pointer and last debounced value
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        hist[i] <= '0;
      end
      pos  <= '0;
      prev <= '0;
    end else if (advance) begin
      hist[pos] <= captured;
      pos       <= pos_next;
      prev      <= deb;
    end
  end

endmodule
